// File: rtl/assert_macros.svh
// Assertion macros shared by the transform unit's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define MVT_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define MVT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mvt_pkg.sv
// Shared widths, types and constants of the matrix-vector transform unit.
`default_nettype none

package mvt_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int FIELD_W   = 32;
   localparam int CSR_W     = 64;
   localparam int HALF_W    = CSR_W / 2;
   localparam int NUM_CSR   = 8;
   localparam int CSR_IDX_W = $clog2(NUM_CSR);
   localparam int NUM_ROWS  = 4;
   localparam int NUM_COLS  = 4;

   localparam int PROD_W  = 2 * DATA_WIDTH;
   localparam int PRODX_W = PROD_W + 1;
   localparam int RND_W   = PRODX_W - FRAC_BITS;
   localparam int TERM_W  = (RND_W > DATA_WIDTH) ? RND_W : DATA_WIDTH;
   localparam int PAIR_W  = TERM_W + 1;
   localparam int SUM_W   = TERM_W + 2;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef word_type [0:NUM_COLS-1] vector_type;
   // indexed [row][col]
   typedef word_type [0:NUM_ROWS-1][0:NUM_COLS-1] matrix_type;
   typedef logic [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic     valid;
      logic     vec3;
      prod_type [0:NUM_ROWS-1][0:NUM_COLS-1] prod;
   } prod_bus_type;

   localparam word_type ONE_FIX = word_type'(64'(1) << FRAC_BITS);

   localparam logic [PRODX_W-1:0] RND_HALF = PRODX_W'(1) << (FRAC_BITS - 1);

   localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) << (DATA_WIDTH - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

   localparam logic signed [FIELD_W-1:0] OUT_MAX = FIELD_W'(SAT_MAX);
   localparam logic signed [FIELD_W-1:0] OUT_MIN = FIELD_W'(SAT_MIN);

endpackage

`default_nettype wire

// File: rtl/matrix_vector_transform.sv
// A transaction passes the input, product, rounding, pair-sum and result
// registers in turn. Throughput: one vector per clock unless stalled; sixteen
// parallel multipliers feed a round / pair-sum / final-sum pipeline; a stall
// holds each full stage whose successor is held, and empty stages ahead
// of it keep filling. Reset (synchronous, active high) empties the pipeline
// and loads the identity matrix into the coefficient registers.
`default_nettype none

module matrix_vector_transform (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [mvt_pkg::FIELD_W-1:0]   req_in_x,
   input  logic [mvt_pkg::FIELD_W-1:0]   req_in_y,
   input  logic [mvt_pkg::FIELD_W-1:0]   req_in_z,
   input  logic [mvt_pkg::FIELD_W-1:0]   req_in_w,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mvt_pkg::FIELD_W-1:0]   rsp_out_x,
   output logic [mvt_pkg::FIELD_W-1:0]   rsp_out_y,
   output logic [mvt_pkg::FIELD_W-1:0]   rsp_out_z,
   output logic [mvt_pkg::FIELD_W-1:0]   rsp_out_w,
   output logic                          rsp_overflow,
   input  logic                          csr_write,
   input  logic [mvt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mvt_pkg::CSR_W-1:0]     csr_wdata
);
   import mvt_pkg::*;

   matrix_type   coef;
   prod_bus_type prod_bus;
   logic         prod_ready;

   mvt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   mvt_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_in_x   (req_in_x),
      .req_in_y   (req_in_y),
      .req_in_z   (req_in_z),
      .req_in_w   (req_in_w),
      .coef       (coef),
      .prod_bus   (prod_bus),
      .prod_ready (prod_ready)
   );

   mvt_acc u_acc (
      .clock        (clock),
      .reset        (reset),
      .prod_bus     (prod_bus),
      .prod_ready   (prod_ready),
      .coef         (coef),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_w    (rsp_out_w),
      .rsp_overflow (rsp_overflow)
   );

endmodule

`default_nettype wire

// File: rtl/mvt_csr.sv
// Matrix coefficient registers, written through the configuration port.
`default_nettype none

module mvt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [mvt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mvt_pkg::CSR_W-1:0]       csr_wdata,
   output mvt_pkg::matrix_type             coef
);
   import mvt_pkg::*;

   matrix_type coef_ff;
   matrix_type coef_in;
   logic [1:0] col_sel;
   logic [1:0] row_lo;
   logic [1:0] row_hi;

   // Register index: upper bits pick the column, low bit the row pair.
   always_comb begin
      col_sel = csr_index[CSR_IDX_W-1:1];
      row_lo  = {csr_index[0], 1'b0};
      row_hi  = {csr_index[0], 1'b1};
      coef_in = coef_ff;
      if (csr_write) begin
         coef_in[row_lo][col_sel] = csr_wdata[DATA_WIDTH-1:0];
         coef_in[row_hi][col_sel] = csr_wdata[HALF_W +: DATA_WIDTH];
      end
   end

   // Reset to identity.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
               coef_ff[r][c] <= (r == c) ? ONE_FIX : '0;
            end
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

`default_nettype wire

// File: rtl/mvt_mul.sv
// Input register and sixteen-product multiplier stage.
`default_nettype none

`include "assert_macros.svh"

module mvt_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [mvt_pkg::FIELD_W-1:0]   req_in_x,
   input  logic [mvt_pkg::FIELD_W-1:0]   req_in_y,
   input  logic [mvt_pkg::FIELD_W-1:0]   req_in_z,
   input  logic [mvt_pkg::FIELD_W-1:0]   req_in_w,
   input  mvt_pkg::matrix_type           coef,
   output mvt_pkg::prod_bus_type         prod_bus,
   input  logic                          prod_ready
);
   import mvt_pkg::*;

   logic       v0_ff, v0_in, en0;
   logic       vec3_0_ff;
   vector_type vec_0_ff;

   logic       v1_ff, v1_in, en1;
   logic       vec3_1_ff;
   prod_type [0:NUM_ROWS-1][0:NUM_COLS-1] prod_1_ff;
   prod_type [0:NUM_ROWS-1][0:NUM_COLS-1] prod_in;

   // A stage loads when it is empty or its content moves on.
   assign en1   = !v1_ff || prod_ready;
   assign en0   = !v0_ff || en1;
   assign v0_in = en0 ? req_valid : v0_ff;
   assign v1_in = en1 ? v0_ff : v1_ff;
   assign req_ready = en0;

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            prod_in[r][c] = $signed(coef[r][c]) * $signed(vec_0_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         vec3_0_ff   <= req_func;
         vec_0_ff[0] <= req_in_x[DATA_WIDTH-1:0];
         vec_0_ff[1] <= req_in_y[DATA_WIDTH-1:0];
         vec_0_ff[2] <= req_in_z[DATA_WIDTH-1:0];
         vec_0_ff[3] <= req_in_w[DATA_WIDTH-1:0];
      end
      if (en1) begin
         vec3_1_ff <= vec3_0_ff;
         prod_1_ff <= prod_in;
      end
   end

   assign prod_bus.valid = v1_ff;
   assign prod_bus.vec3  = vec3_1_ff;
   assign prod_bus.prod  = prod_1_ff;

   `MVT_ASSERT(a_stall_full, !req_ready |-> (v0_ff && v1_ff), "input stalled with a free stage")
   `MVT_ASSERT_NEXT(a_hold_products, v1_ff && !prod_ready, v1_ff && $stable(prod_1_ff),
      "products changed while stalled")

endmodule

`default_nettype wire

// File: rtl/mvt_acc.sv
// Rounding, row summation and saturation stages with the result register.
`default_nettype none

`include "assert_macros.svh"

module mvt_acc (
   input  logic                          clock,
   input  logic                          reset,
   input  mvt_pkg::prod_bus_type         prod_bus,
   output logic                          prod_ready,
   input  mvt_pkg::matrix_type           coef,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mvt_pkg::FIELD_W-1:0]   rsp_out_x,
   output logic [mvt_pkg::FIELD_W-1:0]   rsp_out_y,
   output logic [mvt_pkg::FIELD_W-1:0]   rsp_out_z,
   output logic [mvt_pkg::FIELD_W-1:0]   rsp_out_w,
   output logic                          rsp_overflow
);
   import mvt_pkg::*;

   // rounding stage
   logic v2_ff, v2_in, en2, vec3_2_ff;
   logic [TERM_W-1:0] term_2_ff [0:NUM_ROWS-1][0:NUM_COLS-1];
   logic [TERM_W-1:0] term_in   [0:NUM_ROWS-1][0:NUM_COLS-1];
   logic [PRODX_W-1:0] rnd_ext  [0:NUM_ROWS-1][0:NUM_COLS-1];
   logic [RND_W-1:0]   rnd_val  [0:NUM_ROWS-1][0:NUM_COLS-1];

   // pair-sum stage
   logic v3_ff, v3_in, en3, vec3_3_ff;
   logic [PAIR_W-1:0] pair_3_ff [0:NUM_ROWS-1][0:1];
   logic [PAIR_W-1:0] pair_in   [0:NUM_ROWS-1][0:1];

   // final sum, saturation and result register
   logic v4_ff, v4_in, en4, vec3_4_ff;
   logic [FIELD_W-1:0] out_4_ff [0:NUM_ROWS-1];
   logic [FIELD_W-1:0] out_in   [0:NUM_ROWS-1];
   logic ovf_4_ff, ovf_in;
   logic signed [SUM_W-1:0] sum_val  [0:NUM_ROWS-1];
   logic signed [SUM_W-1:0] clip_val [0:NUM_ROWS-1];
   logic [NUM_ROWS-1:0] row_ovf;

   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign v2_in = en2 ? prod_bus.valid : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;
   assign prod_ready = en2;

   // Round half up; in point mode column 3 enters unscaled.
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            rnd_ext[r][c] = {prod_bus.prod[r][c][PROD_W-1], prod_bus.prod[r][c]} + RND_HALF;
            rnd_val[r][c] = rnd_ext[r][c][PRODX_W-1:FRAC_BITS];
            if (prod_bus.vec3 && (c == NUM_COLS - 1)) begin
               term_in[r][c] = TERM_W'($signed(coef[r][c]));
            end else begin
               term_in[r][c] = TERM_W'($signed(rnd_val[r][c]));
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         pair_in[r][0] = PAIR_W'($signed(term_2_ff[r][0])) + PAIR_W'($signed(term_2_ff[r][1]));
         pair_in[r][1] = PAIR_W'($signed(term_2_ff[r][2])) + PAIR_W'($signed(term_2_ff[r][3]));
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         sum_val[r] = SUM_W'($signed(pair_3_ff[r][0])) + SUM_W'($signed(pair_3_ff[r][1]));
         row_ovf[r] = 1'b0;
         clip_val[r] = sum_val[r];
         if (sum_val[r] > SAT_MAX) begin
            clip_val[r] = SAT_MAX;
            row_ovf[r]  = 1'b1;
         end else if (sum_val[r] < SAT_MIN) begin
            clip_val[r] = SAT_MIN;
            row_ovf[r]  = 1'b1;
         end
         out_in[r] = FIELD_W'(clip_val[r]);
      end
      // Point mode: drop w and its overflow.
      if (vec3_3_ff) begin
         out_in[NUM_ROWS-1]  = '0;
         row_ovf[NUM_ROWS-1] = 1'b0;
      end
      ovf_in = |row_ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         vec3_2_ff <= prod_bus.vec3;
         term_2_ff <= term_in;
      end
      if (en3) begin
         vec3_3_ff <= vec3_2_ff;
         pair_3_ff <= pair_in;
      end
      if (en4) begin
         vec3_4_ff <= vec3_3_ff;
         out_4_ff  <= out_in;
         ovf_4_ff  <= ovf_in;
      end
   end

   assign rsp_valid    = v4_ff;
   assign rsp_out_x    = out_4_ff[0];
   assign rsp_out_y    = out_4_ff[1];
   assign rsp_out_z    = out_4_ff[2];
   assign rsp_out_w    = out_4_ff[3];
   assign rsp_overflow = ovf_4_ff;

   `MVT_ASSERT(a_point_w_zero, (v4_ff && vec3_4_ff) |-> (out_4_ff[NUM_ROWS-1] == '0),
      "point-mode w is not zero")
   `MVT_ASSERT(a_ovf_clipped, (v4_ff && ovf_4_ff) |->
      (out_4_ff[0] == OUT_MAX || out_4_ff[0] == OUT_MIN ||
       out_4_ff[1] == OUT_MAX || out_4_ff[1] == OUT_MIN ||
       out_4_ff[2] == OUT_MAX || out_4_ff[2] == OUT_MIN ||
       out_4_ff[3] == OUT_MAX || out_4_ff[3] == OUT_MIN),
      "overflow flagged without a clipped component")

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 4x4 matrix-vector transform unit.
module tb;
   import mvt_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 10;
   localparam int PIPE_LATENCY = 5;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 80;

   localparam logic FUNC_VEC4 = 1'b0;
   localparam logic FUNC_VEC3 = 1'b1;

   localparam word_type WORD_MAX = word_type'((64'(1) << (DATA_WIDTH - 1)) - 1);
   localparam word_type WORD_MIN = ~WORD_MAX;
   localparam word_type HALF_FIX = ONE_FIX >> 1;
   localparam longint   SUM_HI   = (longint'(1) << (DATA_WIDTH - 1)) - 1;
   localparam longint   SUM_LO   = -SUM_HI - 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      COL0_XY, COL0_ZW, COL1_XY, COL1_ZW, COL2_XY, COL2_ZW, COL3_XY, COL3_ZW
   } coef_reg_type;

   typedef enum int {MAT_TYPICAL, MAT_FULL, MAT_EXTREME} matrix_kind_type;

   typedef struct packed {
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic [FIELD_W-1:0] z;
      logic [FIELD_W-1:0] w;
      logic               overflow;
   } vertex_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_func;
   logic [FIELD_W-1:0]   req_in_x;
   logic [FIELD_W-1:0]   req_in_y;
   logic [FIELD_W-1:0]   req_in_z;
   logic [FIELD_W-1:0]   req_in_w;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [FIELD_W-1:0]   rsp_out_x;
   logic [FIELD_W-1:0]   rsp_out_y;
   logic [FIELD_W-1:0]   rsp_out_z;
   logic [FIELD_W-1:0]   rsp_out_w;
   logic                 rsp_overflow;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   logic [CSR_W-1:0]  matrix_regs [NUM_CSR];
   vertex_result_type expected_results [$];
   vertex_result_type oldest_result;

   int send_idle_pct;
   int stall_pct;
   int quiet_cycles;
   int error_count;
   int vectors_sent;
   int points_sent;
   int results_checked;
   int saturated_seen;
   int register_writes;

   matrix_vector_transform DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_in_x     (req_in_x),
      .req_in_y     (req_in_y),
      .req_in_z     (req_in_z),
      .req_in_w     (req_in_w),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_w    (rsp_out_w),
      .rsp_overflow (rsp_overflow),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Matrix coefficient from the register copy; rows 0/2 in the low half.
   function automatic longint coefficient(int row, int col);
      logic [CSR_W-1:0] pair;
      pair = matrix_regs[col * 2 + row / 2];
      if (row % 2)
         return longint'($signed(pair[HALF_W +: DATA_WIDTH]));
      return longint'($signed(pair[0 +: DATA_WIDTH]));
   endfunction

   // Exact product, round half up to the fixed-point grid.
   function automatic longint round_product(longint a, longint b);
      longint p;
      p = a * b + (longint'(1) << (FRAC_BITS - 1));
      return p >>> FRAC_BITS;
   endfunction

   function automatic vertex_result_type transform_vector(logic func, word_type x, word_type y,
                                                         word_type z, word_type w);
      longint            v [4];
      longint            sum;
      word_type          row_out [4];
      vertex_result_type res;
      v[0] = longint'($signed(x));
      v[1] = longint'($signed(y));
      v[2] = longint'($signed(z));
      v[3] = longint'($signed(w));
      res.overflow = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (func == FUNC_VEC3 && r == NUM_ROWS - 1) begin
            row_out[r] = '0;
         end else begin
            sum = 0;
            for (int c = 0; c < NUM_COLS - 1; c++)
               sum += round_product(coefficient(r, c), v[c]);
            // point mode adds the translation column as it stands
            if (func == FUNC_VEC3)
               sum += coefficient(r, NUM_COLS - 1);
            else
               sum += round_product(coefficient(r, NUM_COLS - 1), v[3]);
            if (sum > SUM_HI) begin
               sum = SUM_HI;
               res.overflow = 1'b1;
            end else if (sum < SUM_LO) begin
               sum = SUM_LO;
               res.overflow = 1'b1;
            end
            row_out[r] = word_type'(sum);
         end
      end
      res.x = FIELD_W'($signed(row_out[0]));
      res.y = FIELD_W'($signed(row_out[1]));
      res.z = FIELD_W'($signed(row_out[2]));
      res.w = FIELD_W'($signed(row_out[3]));
      return res;
   endfunction

   function automatic word_type extreme_word();
      case ($urandom_range(5))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return '0;
         3:       return ONE_FIX;
         4:       return word_type'(-ONE_FIX);
         default: return '1;
      endcase
   endfunction

   function automatic word_type random_component();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5)
         return word_type'(int'($urandom_range(0, 32'h10_0000)) - 32'h8_0000);
      if (pick < 8)
         return word_type'($urandom);
      return extreme_word();
   endfunction

   function automatic matrix_type random_matrix(matrix_kind_type kind);
      matrix_type m;
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            case (kind)
               MAT_TYPICAL: m[r][c] = word_type'(int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000);
               MAT_FULL:    m[r][c] = word_type'($urandom);
               default:     m[r][c] = extreme_word();
            endcase
         end
      end
      return m;
   endfunction

   function automatic matrix_type identity_matrix();
      matrix_type m;
      m = '0;
      for (int i = 0; i < NUM_ROWS; i++)
         m[i][i] = ONE_FIX;
      return m;
   endfunction

   function automatic matrix_type uniform_matrix(word_type value);
      matrix_type m;
      for (int r = 0; r < NUM_ROWS; r++)
         for (int c = 0; c < NUM_COLS; c++)
            m[r][c] = value;
      return m;
   endfunction

   task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                  logic [FIELD_W-1:0] want);
      $display("MISMATCH %s: got %h, expected %h (t=%0t)", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic write_register(coef_reg_type index, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      matrix_regs[index] = data;
      register_writes++;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_matrix(matrix_type m);
      for (int c = 0; c < NUM_COLS; c++)
         for (int h = 0; h < 2; h++)
            write_register(coef_reg_type'(c * 2 + h),
                           {HALF_W'(m[h * 2 + 1][c]), HALF_W'(m[h * 2][c])});
   endtask

   task automatic send_vector(logic func, word_type x, word_type y, word_type z, word_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_in_x  <= FIELD_W'(x);
      req_in_y  <= FIELD_W'(y);
      req_in_z  <= FIELD_W'(z);
      req_in_w  <= FIELD_W'(w);
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_results.push_back(transform_vector(func, x, y, z, w));
      vectors_sent++;
      if (func == FUNC_VEC3)
         points_sent++;
   endtask

   // Drop valid and hold until every pending transaction has returned.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_identity();
      send_vector(FUNC_VEC4, '0, '0, '0, '0);
      send_vector(FUNC_VEC4, WORD_MAX, WORD_MIN, '1, word_type'(1));
      send_vector(FUNC_VEC4, WORD_MIN, WORD_MAX, ONE_FIX, word_type'(-ONE_FIX));
      send_vector(FUNC_VEC3, random_component(), random_component(), random_component(),
                  word_type'($urandom));
      send_vector(FUNC_VEC3, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX);
   endtask

   task automatic test_saturation();
      wait_until_drained();
      load_matrix(uniform_matrix(WORD_MAX));
      send_vector(FUNC_VEC4, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      send_vector(FUNC_VEC4, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_vector(FUNC_VEC3, WORD_MAX, WORD_MAX, WORD_MAX, '0);
      wait_until_drained();
      load_matrix(uniform_matrix(WORD_MIN));
      send_vector(FUNC_VEC4, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_vector(FUNC_VEC3, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_vector(FUNC_VEC4, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
   endtask

   // One-half coefficients put every product of an odd component exactly on a rounding tie.
   task automatic test_rounding();
      wait_until_drained();
      load_matrix(uniform_matrix(HALF_FIX));
      send_vector(FUNC_VEC4, word_type'(1), '0, '0, '0);
      send_vector(FUNC_VEC4, '1, '0, '0, '0);
      send_vector(FUNC_VEC4, '1, '1, '1, '1);
      send_vector(FUNC_VEC4, word_type'(3), word_type'(-3), word_type'(5), word_type'(-5));
      send_vector(FUNC_VEC3, '1, word_type'(1), '0, '1);
   endtask

   // Point mode: w row may be huge but is forced to zero and never saturates.
   task automatic test_point_mode();
      matrix_type m;
      m = '0;
      for (int c = 0; c < NUM_COLS; c++)
         m[NUM_ROWS - 1][c] = WORD_MAX;
      wait_until_drained();
      load_matrix(m);
      send_vector(FUNC_VEC3, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      send_vector(FUNC_VEC4, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      // translation column with odd bits is added exactly
      m = identity_matrix();
      for (int r = 0; r < NUM_ROWS; r++)
         m[r][NUM_COLS - 1] = word_type'($urandom) | word_type'(1);
      wait_until_drained();
      load_matrix(m);
      send_vector(FUNC_VEC3, word_type'(7), word_type'(-9), ONE_FIX, '0);
      send_vector(FUNC_VEC4, word_type'(7), word_type'(-9), ONE_FIX, HALF_FIX);
   endtask

   task automatic test_random_phase(int idle, int stall, matrix_kind_type second_kind);
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int half = 0; half < 2; half++) begin
         wait_until_drained();
         load_matrix(random_matrix(half == 0 ? MAT_TYPICAL : second_kind));
         repeat (PHASE_ITEMS)
            send_vector(logic'($urandom_range(1)), random_component(), random_component(),
                        random_component(), random_component());
      end
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no transaction pending", rsp_out_x, '0);
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_out_x !== oldest_result.x)
               report_mismatch("out_x", rsp_out_x, oldest_result.x);
            if (rsp_out_y !== oldest_result.y)
               report_mismatch("out_y", rsp_out_y, oldest_result.y);
            if (rsp_out_z !== oldest_result.z)
               report_mismatch("out_z", rsp_out_z, oldest_result.z);
            if (rsp_out_w !== oldest_result.w)
               report_mismatch("out_w", rsp_out_w, oldest_result.w);
            if (rsp_overflow !== oldest_result.overflow)
               report_mismatch("overflow", FIELD_W'(rsp_overflow),
                               FIELD_W'(oldest_result.overflow));
            results_checked++;
            if (oldest_result.overflow)
               saturated_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_VEC4;
      req_in_x        = '0;
      req_in_y        = '0;
      req_in_z        = '0;
      req_in_w        = '0;
      rsp_ready       = 1'b0;
      csr_write       = 1'b0;
      csr_index       = COL0_XY;
      csr_wdata       = '0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      quiet_cycles    = 0;
      error_count     = 0;
      vectors_sent    = 0;
      points_sent     = 0;
      results_checked = 0;
      saturated_seen  = 0;
      register_writes = 0;
      matrix_regs[COL0_XY] = CSR_W'(ONE_FIX);
      matrix_regs[COL0_ZW] = '0;
      matrix_regs[COL1_XY] = CSR_W'(ONE_FIX) << HALF_W;
      matrix_regs[COL1_ZW] = '0;
      matrix_regs[COL2_XY] = '0;
      matrix_regs[COL2_ZW] = CSR_W'(ONE_FIX);
      matrix_regs[COL3_XY] = '0;
      matrix_regs[COL3_ZW] = CSR_W'(ONE_FIX) << HALF_W;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_identity();
      test_saturation();
      test_rounding();
      test_point_mode();
      test_random_phase(0, 0, MAT_FULL);
      test_random_phase(50, 0, MAT_EXTREME);
      test_random_phase(0, 50, MAT_FULL);
      test_random_phase(28, 28, MAT_EXTREME);

      wait_until_drained();
      repeat (PIPE_LATENCY * 4) @(posedge clock);
      $display("Sent %0d vectors (%0d in point mode) over %0d register writes,",
               vectors_sent, points_sent, register_writes);
      $display("checked %0d results (%0d saturated) under four idle/stall mixes.",
               results_checked, saturated_seen);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
